/* src/aesd_pkg.sv */
// Constants and functions for the AES-128 block decryption pipeline.
// Holds the substitution tables, GF(2^8) helpers and the round function.
// No dependencies.
package aesd_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] block_t;

	localparam int NUM_ROUNDS = 10;

	localparam logic KEY_HIGH_IDX = 1'b0;
	localparam logic KEY_LOW_IDX = 1'b1;

	function automatic byte_t sbox(input byte_t x);
		byte_t r;
		case (x)
			8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
			8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
			8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
			8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
			8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
			8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
			8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
			8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
			8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
			8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
			8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
			8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
			8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
			8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
			8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
			8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
			8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
			8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
			8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
			8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
			8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
			8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
			8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
			8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
			8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
			8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
			8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
			8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
			8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
			8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
			8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
			8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
			8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
			8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
			8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
			8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
			8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
			8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
			8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
			8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
			8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
			8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
			8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
			8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
			8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
			8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
			8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
			8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
			8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
			8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
			8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
			8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
			8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
			8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
			8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
			8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
			8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
			8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
			8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
			8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
			8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
			8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
			8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
			8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t rev_sbox(input byte_t x);
		byte_t r;
		case (x)
			8'h00: r = 8'h52; 8'h01: r = 8'h09; 8'h02: r = 8'h6a; 8'h03: r = 8'hd5;
			8'h04: r = 8'h30; 8'h05: r = 8'h36; 8'h06: r = 8'ha5; 8'h07: r = 8'h38;
			8'h08: r = 8'hbf; 8'h09: r = 8'h40; 8'h0a: r = 8'ha3; 8'h0b: r = 8'h9e;
			8'h0c: r = 8'h81; 8'h0d: r = 8'hf3; 8'h0e: r = 8'hd7; 8'h0f: r = 8'hfb;
			8'h10: r = 8'h7c; 8'h11: r = 8'he3; 8'h12: r = 8'h39; 8'h13: r = 8'h82;
			8'h14: r = 8'h9b; 8'h15: r = 8'h2f; 8'h16: r = 8'hff; 8'h17: r = 8'h87;
			8'h18: r = 8'h34; 8'h19: r = 8'h8e; 8'h1a: r = 8'h43; 8'h1b: r = 8'h44;
			8'h1c: r = 8'hc4; 8'h1d: r = 8'hde; 8'h1e: r = 8'he9; 8'h1f: r = 8'hcb;
			8'h20: r = 8'h54; 8'h21: r = 8'h7b; 8'h22: r = 8'h94; 8'h23: r = 8'h32;
			8'h24: r = 8'ha6; 8'h25: r = 8'hc2; 8'h26: r = 8'h23; 8'h27: r = 8'h3d;
			8'h28: r = 8'hee; 8'h29: r = 8'h4c; 8'h2a: r = 8'h95; 8'h2b: r = 8'h0b;
			8'h2c: r = 8'h42; 8'h2d: r = 8'hfa; 8'h2e: r = 8'hc3; 8'h2f: r = 8'h4e;
			8'h30: r = 8'h08; 8'h31: r = 8'h2e; 8'h32: r = 8'ha1; 8'h33: r = 8'h66;
			8'h34: r = 8'h28; 8'h35: r = 8'hd9; 8'h36: r = 8'h24; 8'h37: r = 8'hb2;
			8'h38: r = 8'h76; 8'h39: r = 8'h5b; 8'h3a: r = 8'ha2; 8'h3b: r = 8'h49;
			8'h3c: r = 8'h6d; 8'h3d: r = 8'h8b; 8'h3e: r = 8'hd1; 8'h3f: r = 8'h25;
			8'h40: r = 8'h72; 8'h41: r = 8'hf8; 8'h42: r = 8'hf6; 8'h43: r = 8'h64;
			8'h44: r = 8'h86; 8'h45: r = 8'h68; 8'h46: r = 8'h98; 8'h47: r = 8'h16;
			8'h48: r = 8'hd4; 8'h49: r = 8'ha4; 8'h4a: r = 8'h5c; 8'h4b: r = 8'hcc;
			8'h4c: r = 8'h5d; 8'h4d: r = 8'h65; 8'h4e: r = 8'hb6; 8'h4f: r = 8'h92;
			8'h50: r = 8'h6c; 8'h51: r = 8'h70; 8'h52: r = 8'h48; 8'h53: r = 8'h50;
			8'h54: r = 8'hfd; 8'h55: r = 8'hed; 8'h56: r = 8'hb9; 8'h57: r = 8'hda;
			8'h58: r = 8'h5e; 8'h59: r = 8'h15; 8'h5a: r = 8'h46; 8'h5b: r = 8'h57;
			8'h5c: r = 8'ha7; 8'h5d: r = 8'h8d; 8'h5e: r = 8'h9d; 8'h5f: r = 8'h84;
			8'h60: r = 8'h90; 8'h61: r = 8'hd8; 8'h62: r = 8'hab; 8'h63: r = 8'h00;
			8'h64: r = 8'h8c; 8'h65: r = 8'hbc; 8'h66: r = 8'hd3; 8'h67: r = 8'h0a;
			8'h68: r = 8'hf7; 8'h69: r = 8'he4; 8'h6a: r = 8'h58; 8'h6b: r = 8'h05;
			8'h6c: r = 8'hb8; 8'h6d: r = 8'hb3; 8'h6e: r = 8'h45; 8'h6f: r = 8'h06;
			8'h70: r = 8'hd0; 8'h71: r = 8'h2c; 8'h72: r = 8'h1e; 8'h73: r = 8'h8f;
			8'h74: r = 8'hca; 8'h75: r = 8'h3f; 8'h76: r = 8'h0f; 8'h77: r = 8'h02;
			8'h78: r = 8'hc1; 8'h79: r = 8'haf; 8'h7a: r = 8'hbd; 8'h7b: r = 8'h03;
			8'h7c: r = 8'h01; 8'h7d: r = 8'h13; 8'h7e: r = 8'h8a; 8'h7f: r = 8'h6b;
			8'h80: r = 8'h3a; 8'h81: r = 8'h91; 8'h82: r = 8'h11; 8'h83: r = 8'h41;
			8'h84: r = 8'h4f; 8'h85: r = 8'h67; 8'h86: r = 8'hdc; 8'h87: r = 8'hea;
			8'h88: r = 8'h97; 8'h89: r = 8'hf2; 8'h8a: r = 8'hcf; 8'h8b: r = 8'hce;
			8'h8c: r = 8'hf0; 8'h8d: r = 8'hb4; 8'h8e: r = 8'he6; 8'h8f: r = 8'h73;
			8'h90: r = 8'h96; 8'h91: r = 8'hac; 8'h92: r = 8'h74; 8'h93: r = 8'h22;
			8'h94: r = 8'he7; 8'h95: r = 8'had; 8'h96: r = 8'h35; 8'h97: r = 8'h85;
			8'h98: r = 8'he2; 8'h99: r = 8'hf9; 8'h9a: r = 8'h37; 8'h9b: r = 8'he8;
			8'h9c: r = 8'h1c; 8'h9d: r = 8'h75; 8'h9e: r = 8'hdf; 8'h9f: r = 8'h6e;
			8'ha0: r = 8'h47; 8'ha1: r = 8'hf1; 8'ha2: r = 8'h1a; 8'ha3: r = 8'h71;
			8'ha4: r = 8'h1d; 8'ha5: r = 8'h29; 8'ha6: r = 8'hc5; 8'ha7: r = 8'h89;
			8'ha8: r = 8'h6f; 8'ha9: r = 8'hb7; 8'haa: r = 8'h62; 8'hab: r = 8'h0e;
			8'hac: r = 8'haa; 8'had: r = 8'h18; 8'hae: r = 8'hbe; 8'haf: r = 8'h1b;
			8'hb0: r = 8'hfc; 8'hb1: r = 8'h56; 8'hb2: r = 8'h3e; 8'hb3: r = 8'h4b;
			8'hb4: r = 8'hc6; 8'hb5: r = 8'hd2; 8'hb6: r = 8'h79; 8'hb7: r = 8'h20;
			8'hb8: r = 8'h9a; 8'hb9: r = 8'hdb; 8'hba: r = 8'hc0; 8'hbb: r = 8'hfe;
			8'hbc: r = 8'h78; 8'hbd: r = 8'hcd; 8'hbe: r = 8'h5a; 8'hbf: r = 8'hf4;
			8'hc0: r = 8'h1f; 8'hc1: r = 8'hdd; 8'hc2: r = 8'ha8; 8'hc3: r = 8'h33;
			8'hc4: r = 8'h88; 8'hc5: r = 8'h07; 8'hc6: r = 8'hc7; 8'hc7: r = 8'h31;
			8'hc8: r = 8'hb1; 8'hc9: r = 8'h12; 8'hca: r = 8'h10; 8'hcb: r = 8'h59;
			8'hcc: r = 8'h27; 8'hcd: r = 8'h80; 8'hce: r = 8'hec; 8'hcf: r = 8'h5f;
			8'hd0: r = 8'h60; 8'hd1: r = 8'h51; 8'hd2: r = 8'h7f; 8'hd3: r = 8'ha9;
			8'hd4: r = 8'h19; 8'hd5: r = 8'hb5; 8'hd6: r = 8'h4a; 8'hd7: r = 8'h0d;
			8'hd8: r = 8'h2d; 8'hd9: r = 8'he5; 8'hda: r = 8'h7a; 8'hdb: r = 8'h9f;
			8'hdc: r = 8'h93; 8'hdd: r = 8'hc9; 8'hde: r = 8'h9c; 8'hdf: r = 8'hef;
			8'he0: r = 8'ha0; 8'he1: r = 8'he0; 8'he2: r = 8'h3b; 8'he3: r = 8'h4d;
			8'he4: r = 8'hae; 8'he5: r = 8'h2a; 8'he6: r = 8'hf5; 8'he7: r = 8'hb0;
			8'he8: r = 8'hc8; 8'he9: r = 8'heb; 8'hea: r = 8'hbb; 8'heb: r = 8'h3c;
			8'hec: r = 8'h83; 8'hed: r = 8'h53; 8'hee: r = 8'h99; 8'hef: r = 8'h61;
			8'hf0: r = 8'h17; 8'hf1: r = 8'h2b; 8'hf2: r = 8'h04; 8'hf3: r = 8'h7e;
			8'hf4: r = 8'hba; 8'hf5: r = 8'h77; 8'hf6: r = 8'hd6; 8'hf7: r = 8'h26;
			8'hf8: r = 8'he1; 8'hf9: r = 8'h69; 8'hfa: r = 8'h14; 8'hfb: r = 8'h63;
			8'hfc: r = 8'h55; 8'hfd: r = 8'h21; 8'hfe: r = 8'h0c; 8'hff: r = 8'h7d;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t rcon(input logic [3:0] i);
		byte_t r;
		case (i)
			4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
			4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
			4'd9: r = 8'h1b; 4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t xt(input byte_t x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Multiplications by 9, 11, 13 and 14 built from repeated doubling.
	function automatic block_t inv_mix(input block_t s);
		block_t r;
		byte_t a [4];
		byte_t a2 [4];
		byte_t a4 [4];
		byte_t a8 [4];
		byte_t m9 [4];
		byte_t mb [4];
		byte_t md [4];
		byte_t me [4];
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a[j] = s[127 - 8 * (4 * c + j) -: 8];
				a2[j] = xt(a[j]);
				a4[j] = xt(a2[j]);
				a8[j] = xt(a4[j]);
				m9[j] = a8[j] ^ a[j];
				mb[j] = a8[j] ^ a2[j] ^ a[j];
				md[j] = a8[j] ^ a4[j] ^ a[j];
				me[j] = a8[j] ^ a4[j] ^ a2[j];
			end
			r[127 - 8 * (4 * c) -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
			r[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
			r[127 - 8 * (4 * c + 2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
			r[127 - 8 * (4 * c + 3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
		end
		return r;
	endfunction

	function automatic block_t inv_shift_sub(input block_t s);
		block_t r;
		for (int rr = 0; rr < 4; rr++) begin
			for (int c = 0; c < 4; c++) begin
				r[127 - 8 * (4 * c + rr) -: 8] =
					rev_sbox(s[127 - 8 * (4 * ((c + 4 - rr) % 4) + rr) -: 8]);
			end
		end
		return r;
	endfunction

	// One step of the key schedule: next round key from the previous one.
	function automatic block_t next_key(input block_t k, input logic [3:0] rnd);
		block_t r;
		logic [31:0] t;
		logic [31:0] w;
		w = k[31:0];
		t = {sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
		t[31:24] = t[31:24] ^ rcon(rnd);
		r[127:96] = k[127:96] ^ t;
		r[95:64] = k[95:64] ^ r[127:96];
		r[63:32] = k[63:32] ^ r[95:64];
		r[31:0] = k[31:0] ^ r[63:32];
		return r;
	endfunction

endpackage

/* src/aes128_block_decrypt.sv */
// AES-128 block decryption, one inverse round per pipeline stage.
// Depends on aesd_pkg for tables, the key schedule step and the round function.
//
// Channel   Direction  Signals
// config    in         cfg_we, cfg_index, cfg_data
// cipher    in         in_valid, in_ready, cipher_high, cipher_low
// plain     out        out_valid, out_ready, plain_high, plain_low
//
// A block passes through eleven register stages: the input key-add stage and the ten
// round stages. A new beat is taken every cycle while the round keys are ready and the
// pipeline is not held. The round keys are expanded after reset or a key write, one
// schedule step per cycle, and in_ready stays low until they are done.
// When the output beat is not taken the whole pipeline holds, nothing lost.
module aes128_block_decrypt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [63:0]  cipher_high,
	input  logic [63:0]  cipher_low,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [63:0]  plain_high,
	output logic [63:0]  plain_low
);

	localparam int NR = aesd_pkg::NUM_ROUNDS;

	aesd_pkg::block_t key_q;
	aesd_pkg::block_t rk_q [NR + 1];
	logic [3:0] step_q;
	aesd_pkg::block_t st_s [NR + 1];
	logic [NR:0] vld_s;
	logic adv;
	logic keys_ready;

	// Key expansion sweep: rk_q[i] is round key i.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			step_q <= 4'd0;
		end else if (cfg_we) begin
			if (cfg_index == aesd_pkg::KEY_LOW_IDX) key_q[63:0] <= cfg_data;
			else key_q[127:64] <= cfg_data;
			step_q <= 4'd0;
		end else if (step_q <= 4'(NR)) begin
			step_q <= step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		rk_q[0] <= key_q;
		for (int i = 1; i <= NR; i++) begin
			if (step_q == 4'(i)) rk_q[i] <= aesd_pkg::next_key(rk_q[i - 1], 4'(i));
		end
	end

	assign keys_ready = (step_q > 4'(NR));
	assign adv = !vld_s[NR] || out_ready;
	assign in_ready = adv && keys_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NR - 1:0], in_valid && keys_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= {cipher_high, cipher_low} ^ rk_q[NR];
			for (int i = 1; i < NR; i++) begin
				st_s[i] <= aesd_pkg::inv_mix(aesd_pkg::inv_shift_sub(st_s[i - 1]) ^ rk_q[NR - i]);
			end
			st_s[NR] <= aesd_pkg::inv_shift_sub(st_s[NR - 1]) ^ rk_q[0];
		end
	end

	assign out_valid = vld_s[NR];
	assign plain_high = st_s[NR][127:64];
	assign plain_low = st_s[NR][63:0];

endmodule

/* tb/aesd_plain_checker.sv */
// Checker for the AES-128 decryption block: tracks key writes, predicts the plaintext of
// every accepted ciphertext beat and compares each plaintext beat in order.
// Builds its own substitution tables; takes the register indexes from aesd_pkg.
`timescale 1ns / 100ps

module aesd_plain_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] cipher_high,
	input  logic [63:0] cipher_low,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output int          fail_count,
	output int          waiting,
	output int          blocks_checked
);

	logic [7:0] fwd_sub [256];
	logic [7:0] rev_sub [256];
	logic [63:0] key_hi;
	logic [63:0] key_lo;
	logic [127:0] plain_due [$];

	function automatic logic [7:0] dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				p ^= a;
			a = dbl(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] rol8(input logic [7:0] b, input int n);
		logic [7:0] r;
		r = (b << n) | (b >> (8 - n));
		return r;
	endfunction

	// Builds the S-box as the affine map of the field inverse, and its inverse table.
	initial begin
		logic [7:0] inv;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (gf_mul(x[7:0], y[7:0]) == 8'h01)
					inv = y[7:0];
			end
			s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
			fwd_sub[x] = s;
			rev_sub[s] = x[7:0];
		end
	end

	function automatic logic [127:0] inv_cipher(input logic [127:0] blk,
			input logic [63:0] khi, input logic [63:0] klo);
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0] rc;
		logic [7:0] s [16];
		logic [7:0] u [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] r;
		w[0] = khi[63:32];
		w[1] = khi[31:0];
		w[2] = klo[63:32];
		w[3] = klo[31:0];
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if (i % 4 == 0) begin
				t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]],
					fwd_sub[t[31:24]]};
				rc = dbl(rc);
			end
			w[i] = w[i - 4] ^ t;
		end
		for (int i = 0; i < 16; i++)
			s[i] = blk[127 - 8 * i -: 8];
		for (int rnd = 10; rnd >= 0; rnd--) begin
			if (rnd < 10) begin
				for (int rw = 0; rw < 4; rw++)
					for (int c = 0; c < 4; c++)
						u[4 * c + rw] = rev_sub[s[4 * ((c + 4 - rw) % 4) + rw]];
				s = u;
			end
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					s[4 * c + j] ^= w[4 * rnd + c][31 - 8 * j -: 8];
			if (rnd > 0 && rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4 * c];
					a1 = s[4 * c + 1];
					a2 = s[4 * c + 2];
					a3 = s[4 * c + 3];
					s[4 * c] = gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b) ^ gf_mul(a2, 8'h0d)
						^ gf_mul(a3, 8'h09);
					s[4 * c + 1] = gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e) ^ gf_mul(a2, 8'h0b)
						^ gf_mul(a3, 8'h0d);
					s[4 * c + 2] = gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09) ^ gf_mul(a2, 8'h0e)
						^ gf_mul(a3, 8'h0b);
					s[4 * c + 3] = gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d) ^ gf_mul(a2, 8'h09)
						^ gf_mul(a3, 8'h0e);
				end
			end
		end
		for (int i = 0; i < 16; i++)
			r[127 - 8 * i -: 8] = s[i];
		return r;
	endfunction

	assign waiting = plain_due.size();

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			key_hi <= 64'h0;
			key_lo <= 64'h0;
			fail_count <= 0;
			blocks_checked <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == aesd_pkg::KEY_HIGH_IDX)
					key_hi <= cfg_data;
				else
					key_lo <= cfg_data;
			end
			if (in_valid && in_ready)
				plain_due.push_back(inv_cipher({cipher_high, cipher_low}, key_hi, key_lo));
			if (out_valid && out_ready) begin
				blocks_checked <= blocks_checked + 1;
				if (plain_due.size() == 0) begin
					$display("%0t: plaintext beat with none expected: %h %h", $realtime,
						plain_high, plain_low);
					fail_count <= fail_count + 1;
				end else begin
					want = plain_due.pop_front();
					if (plain_high !== want[127:64] || plain_low !== want[63:0]) begin
						if (plain_high !== want[127:64])
							$display("%0t: plain_high expected %h, got %h", $realtime,
								want[127:64], plain_high);
						if (plain_low !== want[63:0])
							$display("%0t: plain_low expected %h, got %h", $realtime,
								want[63:0], plain_low);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the AES-128 decryption testbench: clock, reset, key writes and ciphertext beats
// with random idling on both sides, and the verdict. Depends on aes128_block_decrypt,
// aesd_pkg and on aesd_plain_checker for prediction and comparison.
`timescale 1ns / 100ps

module testbench;

	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = aesd_pkg::KEY_HIGH_IDX;
	logic [63:0] cfg_data = 64'h0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [63:0] cipher_high = 64'h0;
	logic [63:0] cipher_low = 64'h0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic calm = 1'b0;
	int fail_count;
	int waiting;
	int blocks_checked;
	int quiet_cycles = 0;
	int keys_used = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aes128_block_decrypt dut (.*);

	aesd_plain_checker chk (.*);

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 31);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** aes128_block_decrypt: FAILED **");
			$finish;
		end
	end

	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		if (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 31);
		end
		cipher_high <= hi;
		cipher_low <= lo;
		in_valid <= 1'b1;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Keys change only with the pipeline empty, then the schedule gets time to settle.
	task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= aesd_pkg::KEY_HIGH_IDX;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= aesd_pkg::KEY_LOW_IDX;
		cfg_data <= lo;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (15) @(posedge clk);
		keys_used++;
	endtask

	task automatic random_blocks(input int count);
		for (int i = 0; i < count; i++)
			send_block({$urandom, $urandom}, {$urandom, $urandom});
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (15) @(posedge clk);

		// Reset key of all zeros.
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block(64'h8000000000000000, 64'h0000000000000001);
		random_blocks(100);

		load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		for (int b = 0; b < 128; b += 9) begin
			logic [127:0] one;
			one = 128'h1 << b;
			send_block(one[127:64], one[63:0]);
		end
		random_blocks(150);

		load_key('1, '1);
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		random_blocks(150);

		load_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		calm <= 1'b1;
		random_blocks(200);
		calm <= 1'b0;

		for (int k = 0; k < 3; k++) begin
			load_key({$urandom, $urandom}, {$urandom, $urandom});
			random_blocks(140);
		end

		load_key(64'h0, 64'h0);
		random_blocks(10);

		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d plaintext blocks under %0d keys, with random and directed",
			blocks_checked, keys_used + 1);
		$display("ciphertext and random idling on both channels.");
		if (fail_count == 0 && waiting == 0)
			$display("** aes128_block_decrypt: PASSED **");
		else
			$display("** aes128_block_decrypt: FAILED **");
		$finish;
	end

endmodule

/* aes128_block_decrypt.f */
src/aesd_pkg.sv
src/aes128_block_decrypt.sv
tb/aesd_plain_checker.sv
tb/testbench.sv
